[hdl/nps_pkg.sv]
// shared types and constants for the nearest-previous-smaller search block
// no dependencies; used by nps_cmp and nearest_previous_smaller_within_k
package nps_pkg;

	localparam int HISTORY_DEPTH = 1024;

	localparam int VALUE_W   = 32;
	localparam int DIFF_W    = 31;
	localparam int NEAREST_W = 11;
	localparam int POS_W     = 10;

	// nearest_position when no earlier entry qualifies
	localparam logic signed [NEAREST_W-1:0] NEAREST_NONE = '1;

	localparam logic [DIFF_W-1:0] MAX_DIFF_RESET = 31'd1;

	// byte address of the max_difference register
	localparam logic [1:0] ADDR_MAX_DIFF = 2'd0;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      start_req;
	} item_t;

	typedef struct packed {
		logic signed [NEAREST_W-1:0] nearest_position;
		logic [POS_W-1:0]            position;
		logic                        overflow;
	} result_t;

endpackage

[hdl/nps_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module nps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/nps_cmp.sv]
// shared compare unit: earlier value is smaller and within max_difference
// depends on nps_pkg
module nps_cmp (
	input  logic signed [nps_pkg::VALUE_W-1:0] cur,
	input  logic signed [nps_pkg::VALUE_W-1:0] prev,
	input  logic [nps_pkg::DIFF_W-1:0]         max_diff,
	output logic                               hit
);

	logic signed [nps_pkg::VALUE_W:0] diff;

	// one 33-bit subtract; a clear sign bit and a nonzero difference tell prev < cur
	assign diff = {cur[nps_pkg::VALUE_W-1], cur} - {prev[nps_pkg::VALUE_W-1], prev};

	assign hit = !diff[nps_pkg::VALUE_W] && (diff != '0)
		&& (diff[nps_pkg::VALUE_W-1:0] <= nps_pkg::VALUE_W'(max_diff));

endmodule

[hdl/nearest_previous_smaller_within_k.sv]
// Nearest previous smaller value within max_difference. Each accepted item that fits the history
// is stored at its position in a history RAM, then the history is read backwards one entry per
// clock through a single compare unit until an earlier value below it by at most max_difference
// is found or entry 0 has been compared. The block takes no new item before the current result
// is out: item_stall is high while an item is in flight, until the result transfer completes. A
// start_req item restarts at position 0; items past HISTORY_DEPTH report overflow with
// nearest_position -1 until the next start. No clearing pass is needed after reset.
// depends on nps_pkg, nps_ram, nps_cmp
module nearest_previous_smaller_within_k #(
	parameter int HISTORY_DEPTH = nps_pkg::HISTORY_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  nps_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output nps_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [1:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [1:0] {IDLE, SCAN, OUT} state_t;

	state_t                               state_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic [ADDR_W-1:0]                    pos_q;
	logic signed [nps_pkg::VALUE_W-1:0]   cur_q;
	logic [ADDR_W-1:0]                    rd_idx_q;
	logic                                 more_q;
	logic                                 dv_q;
	logic [ADDR_W-1:0]                    didx_q;
	logic [nps_pkg::DIFF_W-1:0]           max_diff_q;
	nps_pkg::result_t                     res_q;

	logic                                 accept;
	logic [CNT_W-1:0]                     cnt_eff;
	logic                                 full;
	logic                                 ram_we;
	logic                                 ram_re;
	logic [nps_pkg::VALUE_W-1:0]          ram_rdata;
	logic                                 hit;
	logic                                 cfg_wr;

	assign item_stall   = (state_q != IDLE);
	assign accept       = item_valid && !item_stall;
	assign cnt_eff      = item.start_req ? '0 : cnt_q;
	assign full         = (cnt_eff == CNT_W'(HISTORY_DEPTH));
	assign ram_we       = accept && !full;
	assign ram_re       = (state_q == SCAN) && more_q;

	assign result_valid = (state_q == OUT);
	assign result       = res_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == nps_pkg::ADDR_MAX_DIFF);
	assign prdata = {1'b0, max_diff_q};

	nps_ram #(
		.WIDTH(nps_pkg::VALUE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_eff[ADDR_W-1:0]),
		.wdata(item.value),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	nps_cmp u_cmp (
		.cur     (cur_q),
		.prev    (ram_rdata),
		.max_diff(max_diff_q),
		.hit     (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			cnt_q      <= '0;
			more_q     <= 1'b0;
			dv_q       <= 1'b0;
			max_diff_q <= nps_pkg::MAX_DIFF_RESET;
		end else begin
			if (cfg_wr) begin
				max_diff_q <= pwdata[nps_pkg::DIFF_W-1:0];
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						if (full) begin
							cnt_q   <= cnt_eff;
							res_q   <= '{nps_pkg::NEAREST_NONE, '0, 1'b1};
							state_q <= OUT;
						end else begin
							cnt_q  <= cnt_eff + CNT_W'(1);
							pos_q  <= cnt_eff[ADDR_W-1:0];
							cur_q  <= item.value;
							dv_q   <= 1'b0;
							if (cnt_eff == '0) begin
								res_q   <= '{nps_pkg::NEAREST_NONE, '0, 1'b0};
								state_q <= OUT;
							end else begin
								rd_idx_q <= cnt_eff[ADDR_W-1:0] - ADDR_W'(1);
								more_q   <= 1'b1;
								state_q  <= SCAN;
							end
						end
					end
				end
				SCAN: begin
					// read issued one cycle, compared the next
					dv_q   <= more_q;
					didx_q <= rd_idx_q;
					if (more_q) begin
						if (rd_idx_q == '0) begin
							more_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q - ADDR_W'(1);
						end
					end
					if (dv_q && hit) begin
						res_q   <= '{nps_pkg::NEAREST_W'(didx_q), nps_pkg::POS_W'(pos_q), 1'b0};
						more_q  <= 1'b0;
						dv_q    <= 1'b0;
						state_q <= OUT;
					end else if (dv_q && (didx_q == '0)) begin
						res_q   <= '{nps_pkg::NEAREST_NONE, nps_pkg::POS_W'(pos_q), 1'b0};
						more_q  <= 1'b0;
						dv_q    <= 1'b0;
						state_q <= OUT;
					end
				end
				OUT: begin
					if (!result_stall) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// item count never passes the history depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("item count beyond history depth");

	// compared entries always lie below the current position
	a_scan_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) && dv_q |-> didx_q < pos_q)
		else $error("scan compared an entry at or above current position");

	// an overflow result never carries a found position
	a_ovf_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.nearest_position == nps_pkg::NEAREST_NONE)
		else $error("overflow result with a found position");

	// the ram is never read and written in the same cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("history ram read and write collide");

endmodule
